/* rtl/core/assert_macros.svh */
// assertion macros shared by the voltage checker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define VCHK_ASSERT_IMPL(lbl, clk, rst, ant, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, off while reset is high
`define VCHK_ASSERT_NEXT(lbl, clk, rst, ant, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* rtl/core/vchk_pkg.sv */
// shared types, codes and the crc byte update for the voltage checker
package vchk_pkg;

   localparam logic [15:0] CRC_SEED   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam int unsigned MIN_FRAME  = 5;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FUNCTION_CODE       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_BYTE_COUNT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_ZONE           = 2'd3;

   localparam logic [7:0]  RST_DEVICE_ADDRESS      = 8'd1;
   localparam logic [6:0]  RST_FUNCTION_CODE       = 7'd3;
   localparam logic [7:0]  RST_EXPECTED_BYTE_COUNT = 8'd4;
   localparam logic [15:0] RST_DEAD_ZONE           = 16'd20;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_FAULT     = 3'd1,
      STATUS_CRC_ERR   = 3'd2,
      STATUS_EXCEPTION = 3'd3,
      STATUS_BAD_HDR   = 3'd4
   } vchk_status_type;

   typedef struct packed {
      logic [7:0]  device_address;
      logic [6:0]  function_code;
      logic [7:0]  expected_byte_count;
      logic [15:0] dead_zone;
   } vchk_cfg_type;

   typedef struct packed {
      logic [30:0]     voltage_hundredths;
      vchk_status_type status;
   } vchk_result_type;

   // reflected crc-16, one byte, lsb first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

/* rtl/core/vchk_csr_regs.sv */
// configuration registers of the voltage checker
module vchk_csr_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [vchk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vchk_pkg::CSR_DATA_W-1:0]  csr_data,
   output vchk_pkg::vchk_cfg_type            cfg
);
   import vchk_pkg::*;

   vchk_cfg_type cfg_ff;
   vchk_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS:      cfg_in.device_address      = csr_data[7:0];
            CSR_FUNCTION_CODE:       cfg_in.function_code       = csr_data[6:0];
            CSR_EXPECTED_BYTE_COUNT: cfg_in.expected_byte_count = csr_data[7:0];
            CSR_DEAD_ZONE:           cfg_in.dead_zone           = csr_data[15:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address      <= RST_DEVICE_ADDRESS;
         cfg_ff.function_code       <= RST_FUNCTION_CODE;
         cfg_ff.expected_byte_count <= RST_EXPECTED_BYTE_COUNT;
         cfg_ff.dead_zone           <= RST_DEAD_ZONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/vchk_frame_track.sv */
// per-frame state: crc, header and value capture, end-of-frame status
`include "assert_macros.svh"

module vchk_frame_track #(
   parameter int unsigned MAX_FRAME = 100
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_valid,
   input  logic [7:0]                rx_byte,
   input  logic                      frame_end,
   input  logic                      rx_fault,
   input  vchk_pkg::vchk_cfg_type    cfg,
   output vchk_pkg::vchk_result_type result
);
   import vchk_pkg::*;

   localparam int unsigned PW = $clog2(MAX_FRAME + 1);

   logic [PW-1:0] pos_ff, pos_in;
   logic [15:0]   crc_running_ff, crc_running_in;
   logic [15:0]   crc_before_ff, crc_before_in;
   logic [15:0]   last_two_ff, last_two_in;
   logic [23:0]   header_ff, header_in;
   logic [31:0]   value_ff, value_in;
   logic          fault_seen_ff, fault_seen_in;

   logic          byte_taken;
   logic          addr_match;

   always_comb begin
      pos_in         = pos_ff;
      crc_running_in = crc_running_ff;
      crc_before_in  = crc_before_ff;
      last_two_in    = last_two_ff;
      header_in      = header_ff;
      value_in       = value_ff;
      fault_seen_in  = fault_seen_ff | rx_fault;
      byte_taken     = pos_ff < PW'(MAX_FRAME);

      if (byte_taken) begin
         // crc lags one byte so the last two bytes can be left out at frame end
         if (pos_ff != '0) begin
            crc_before_in  = crc_running_ff;
            crc_running_in = crc_feed(crc_running_ff, last_two_ff[15:8]);
         end
         last_two_in = {rx_byte, last_two_ff[15:8]};
         if (pos_ff == PW'(0)) header_in[23:16] = rx_byte;
         if (pos_ff == PW'(1)) header_in[15:8]  = rx_byte;
         if (pos_ff == PW'(2)) header_in[7:0]   = rx_byte;
         if (pos_ff == PW'(3)) value_in[31:24]  = rx_byte;
         if (pos_ff == PW'(4)) value_in[23:16]  = rx_byte;
         if (pos_ff == PW'(5)) value_in[15:8]   = rx_byte;
         if (pos_ff == PW'(6)) value_in[7:0]    = rx_byte;
         pos_in = pos_ff + PW'(1);
      end
   end

   assign addr_match = header_in[23:16] == cfg.device_address;

   always_comb begin
      result.voltage_hundredths = '0;
      if (fault_seen_in || (pos_in < PW'(MIN_FRAME))) begin
         result.status = STATUS_FAULT;
      end else if (crc_before_in != last_two_in) begin
         result.status = STATUS_CRC_ERR;
      end else if (addr_match && (header_in[15:8] == {1'b0, cfg.function_code})
                   && (header_in[7:0] == cfg.expected_byte_count)) begin
         result.status = STATUS_OK;
         // negatives and values under the dead zone read as zero
         if (!value_in[31] && (value_in >= {16'h0000, cfg.dead_zone})) begin
            result.voltage_hundredths = value_in[30:0];
         end
      end else if (addr_match && (header_in[15:8] == {1'b1, cfg.function_code})) begin
         result.status = STATUS_EXCEPTION;
      end else begin
         result.status = STATUS_BAD_HDR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         crc_running_ff <= CRC_SEED;
         crc_before_ff  <= CRC_SEED;
         last_two_ff    <= '0;
         header_ff      <= '0;
         value_ff       <= '0;
         fault_seen_ff  <= 1'b0;
      end else if (step_valid) begin
         value_ff <= value_in;
         if (frame_end) begin
            pos_ff         <= '0;
            crc_running_ff <= CRC_SEED;
            crc_before_ff  <= CRC_SEED;
            last_two_ff    <= '0;
            header_ff      <= '0;
            fault_seen_ff  <= 1'b0;
         end else begin
            pos_ff         <= pos_in;
            crc_running_ff <= crc_running_in;
            crc_before_ff  <= crc_before_in;
            last_two_ff    <= last_two_in;
            header_ff      <= header_in;
            fault_seen_ff  <= fault_seen_in;
         end
      end
   end

   `VCHK_ASSERT_IMPL(a_pos_bounded, clock, reset, 1'b1, pos_ff <= PW'(MAX_FRAME))
   `VCHK_ASSERT_NEXT(a_frame_cleared, clock, reset, step_valid && frame_end,
                     pos_ff == '0 && !fault_seen_ff && crc_running_ff == CRC_SEED)
   `VCHK_ASSERT_NEXT(a_idle_hold, clock, reset, !step_valid, $stable(pos_ff))

endmodule

/* rtl/core/modbus_reply_voltage_checker_top.sv */
// Result: the byte with tlast is held in the input register; when it steps the frame tracker,
// the result register and rsp_tvalid load together.
// Throughput: one byte per cycle; a byte with tlast waits only while the previous result
// is still held in the result register, other bytes never wait on the response side.
// Reset: synchronous, active high; loads the register defaults, clears frame state,
// the held value bytes and both valid flags; no clearing pass is needed.
`include "assert_macros.svh"

module modbus_reply_voltage_checker_top #(
   parameter int unsigned MAX_FRAME = 100
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] rx_byte
   input  logic                              req_tlast,   // frame_end
   input  logic                              req_tuser,   // [0] rx_fault
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,   // [2:0] status, [33:3] voltage_hundredths
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vchk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vchk_pkg::CSR_DATA_W-1:0]  csr_data
);
   import vchk_pkg::*;

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   logic            in_fault_ff;
   logic            out_valid_ff, out_valid_in;
   vchk_result_type out_result_ff;

   vchk_cfg_type    cfg;
   vchk_result_type result;
   logic            out_free;
   logic            step;

   assign csr_ready = 1'b1;

   vchk_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // a byte without tlast never waits on the response side
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || step;

   vchk_frame_track #(
      .MAX_FRAME (MAX_FRAME)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step),
      .rx_byte    (in_byte_ff),
      .frame_end  (in_last_ff),
      .rx_fault   (in_fault_ff),
      .cfg        (cfg),
      .result     (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (step && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff  <= req_tdata;
         in_last_ff  <= req_tlast;
         in_fault_ff <= req_tuser;
      end
      if (step && in_last_ff) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b000000, out_result_ff};

   `VCHK_ASSERT_NEXT(a_result_loaded, clock, reset, step && in_last_ff, rsp_tvalid)
   `VCHK_ASSERT_IMPL(a_volts_only_ok, clock, reset,
                     rsp_tvalid && (out_result_ff.voltage_hundredths != '0),
                     out_result_ff.status == STATUS_OK)
   `VCHK_ASSERT_IMPL(a_no_overwrite, clock, reset, step && in_last_ff,
                     !rsp_tvalid || rsp_tready)

endmodule

/* tb/modbus_reply_voltage_checker_checker.sv */
// scoreboard for the voltage checker: decodes each reply frame and compares the readings
module modbus_reply_voltage_checker_checker #(
   parameter int unsigned MAX_FRAME = 100
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] rx_byte
   input  logic                             req_tlast,   // frame_end
   input  logic                             req_tuser,   // [0] rx_fault
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [39:0]                      rsp_tdata,   // [2:0] status, [33:3] voltage_hundredths
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [vchk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vchk_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               fail_count,
   output int                               pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import vchk_pkg::*;

   typedef struct {
      vchk_status_type status;
      logic [30:0]     volts;
   } reading_type;

   reading_type reading_q[$];

   logic [7:0]  cfg_addr;
   logic [6:0]  cfg_func;
   logic [7:0]  cfg_count;
   logic [15:0] cfg_dead_zone;

   int          frame_pos;
   logic [15:0] crc_run;
   logic [15:0] crc_lag;
   logic [15:0] tail_bytes;
   logic [23:0] hdr_bytes;
   logic [31:0] value_bytes;
   logic        frame_fault;

   function automatic logic [15:0] crc16_step(input logic [15:0] crc_in, input logic [7:0] b);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, b};
      repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      return crc;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: reading mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic clear_frame();
      frame_pos   = 0;
      crc_run     = CRC_SEED;
      crc_lag     = CRC_SEED;
      tail_bytes  = '0;
      hdr_bytes   = '0;
      frame_fault = 1'b0;
   endtask

   task automatic absorb_byte(input logic [7:0] b, input logic eof, input logic flt);
      reading_type r;
      logic [7:0]  a0;
      logic [7:0]  f1;
      logic [7:0]  c2;
      if (flt) frame_fault = 1'b1;
      // bytes past the frame limit only bring their flags
      if (frame_pos < MAX_FRAME) begin
         // the crc trails by one byte so the final two can be compared
         if (frame_pos >= 1) begin
            crc_lag = crc_run;
            crc_run = crc16_step(crc_run, tail_bytes[15:8]);
         end
         tail_bytes = {b, tail_bytes[15:8]};
         if (frame_pos < 3) begin
            hdr_bytes[(2 - frame_pos) * 8 +: 8] = b;
         end else if (frame_pos < 7) begin
            value_bytes[(6 - frame_pos) * 8 +: 8] = b;
         end
         frame_pos++;
      end
      if (eof) begin
         {a0, f1, c2} = hdr_bytes;
         r.volts = '0;
         if (frame_fault || frame_pos < MIN_FRAME) begin
            r.status = STATUS_FAULT;
         end else if (crc_lag != tail_bytes) begin
            r.status = STATUS_CRC_ERR;
         end else if (a0 == cfg_addr && f1 == {1'b0, cfg_func} && c2 == cfg_count) begin
            r.status = STATUS_OK;
            if (!value_bytes[31] && value_bytes >= {16'h0000, cfg_dead_zone}) begin
               r.volts = value_bytes[30:0];
            end
         end else if (a0 == cfg_addr && f1 == {1'b1, cfg_func}) begin
            r.status = STATUS_EXCEPTION;
         end else begin
            r.status = STATUS_BAD_HDR;
         end
         reading_q.push_back(r);
         clear_frame();
      end
   endtask

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         cfg_addr      = RST_DEVICE_ADDRESS;
         cfg_func      = RST_FUNCTION_CODE;
         cfg_count     = RST_EXPECTED_BYTE_COUNT;
         cfg_dead_zone = RST_DEAD_ZONE;
         value_bytes   = '0;
         clear_frame();
         reading_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reading_q.size() == 0) begin
               report_mismatch($sformatf("reading with no frame pending, status %0d",
                                         rsp_tdata[2:0]));
            end else begin
               want = reading_q.pop_front();
               if (rsp_tdata[2:0] !== want.status) begin
                  report_mismatch($sformatf("status %0d, wanted %0d",
                                            rsp_tdata[2:0], want.status));
               end
               if (rsp_tdata[33:3] !== want.volts) begin
                  report_mismatch($sformatf("voltage %0d, wanted %0d",
                                            rsp_tdata[33:3], want.volts));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEVICE_ADDRESS:      cfg_addr = csr_data[7:0];
               CSR_FUNCTION_CODE:       cfg_func = csr_data[6:0];
               CSR_EXPECTED_BYTE_COUNT: cfg_count = csr_data[7:0];
               CSR_DEAD_ZONE:           cfg_dead_zone = csr_data;
            endcase
         end
         if (req_tvalid && req_tready) begin
            absorb_byte(req_tdata, req_tlast, req_tuser);
         end
      end
      pending = reading_q.size();
   end

endmodule

/* tb/tb_modbus_reply_voltage_checker_top.sv */
// testbench top for the voltage checker: drives reply frames and register writes, gives the verdict
module tb_modbus_reply_voltage_checker_top;
   timeunit 1ns;
   timeprecision 1ps;
   import vchk_pkg::*;

   localparam int unsigned FRAME_LIMIT   = 100;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          SETTLE_CYCLES = 6;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [7:0] rx_byte
   logic                   req_tlast;   // frame_end
   logic                   req_tuser;   // [0] rx_fault
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [39:0]            rsp_tdata;   // [2:0] status, [33:3] voltage_hundredths
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int                     fail_count;
   int                     pending;

   idle_mode_type          idle_mode;
   bit                     hold_request;
   int                     bytes_sent;
   logic [7:0]             frame_buf[$];

   logic [7:0]             cfg_addr;
   logic [6:0]             cfg_func;
   logic [7:0]             cfg_count;
   logic [15:0]            cfg_dead_zone;

   always #10 clock = ~clock;

   modbus_reply_voltage_checker_top #(.MAX_FRAME(FRAME_LIMIT)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   modbus_reply_voltage_checker_checker #(.MAX_FRAME(FRAME_LIMIT)) u_reading_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   function automatic logic [15:0] frame_crc();
      logic [15:0] crc;
      crc = CRC_SEED;
      foreach (frame_buf[i]) begin
         crc ^= {8'h00, frame_buf[i]};
         repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
      return crc;
   endfunction

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(5))
         0: v = $urandom_range(cfg_dead_zone);
         1: v = {16'h0000, cfg_dead_zone} - 32'd1;
         2: v = {16'h0000, cfg_dead_zone};
         3: v = {1'b1, 31'($urandom)};
         4: v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic start_frame(input logic [7:0] a, input logic [7:0] f, input logic [7:0] c);
      frame_buf.delete();
      frame_buf.push_back(a);
      frame_buf.push_back(f);
      frame_buf.push_back(c);
   endtask

   task automatic push_random(input int n);
      repeat (n) frame_buf.push_back(8'($urandom_range(255)));
   endtask

   task automatic push_value(input logic [31:0] v);
      frame_buf.push_back(v[31:24]);
      frame_buf.push_back(v[23:16]);
      frame_buf.push_back(v[15:8]);
      frame_buf.push_back(v[7:0]);
   endtask

   task automatic seal_frame();
      logic [15:0] crc;
      crc = frame_crc();
      frame_buf.push_back(crc[7:0]);
      frame_buf.push_back(crc[15:8]);
   endtask

   task automatic good_frame();
      int len;
      len = ($urandom_range(99) < 70) ? 4 : $urandom_range(8);
      start_frame(cfg_addr, {1'b0, cfg_func}, cfg_count);
      if (len >= 4) begin
         push_value(pick_value());
         push_random(len - 4);
      end else begin
         push_random(len);
      end
      seal_frame();
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eof, input logic flt);
      int gap;
      gap = 0;
      if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
         while ($urandom_range(99) < 82) gap++;
      end
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eof;
      req_tuser  <= flt;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_frame(input int fault_at, input int fault_pct);
      logic flt;
      for (int i = 0; i < frame_buf.size(); i++) begin
         flt = (i == fault_at) || ($urandom_range(99) < fault_pct);
         send_byte(frame_buf[i], i == frame_buf.size() - 1, flt);
      end
   endtask

   // valid reply filling the frame limit exactly, then bytes that must be dropped
   task automatic overlong_frame();
      int extra;
      extra = $urandom_range(1, 20);
      start_frame(cfg_addr, {1'b0, cfg_func}, cfg_count);
      push_value(pick_value());
      push_random(FRAME_LIMIT - 9);
      seal_frame();
      push_random(extra);
      send_frame(($urandom_range(3) == 0) ? FRAME_LIMIT + $urandom_range(extra - 1) : -1, 0);
   endtask

   task automatic random_frame();
      int         roll;
      logic [7:0] a;
      logic [7:0] f;
      logic [7:0] c;
      roll = $urandom_range(99);
      if (roll < 50) begin
         good_frame();
         send_frame(-1, 0);
      end else if (roll < 58) begin
         start_frame(cfg_addr, {1'b1, cfg_func}, 8'($urandom_range(255)));
         push_random($urandom_range(2));
         seal_frame();
         send_frame(-1, 0);
      end else if (roll < 66) begin
         a = cfg_addr;
         f = {1'b0, cfg_func};
         c = cfg_count;
         case ($urandom_range(3))
            0: a ^= 8'($urandom_range(1, 255));
            1: f ^= 8'($urandom_range(1, 255));
            2: c ^= 8'($urandom_range(1, 255));
            default: begin
               a = 8'($urandom_range(255));
               f = 8'($urandom_range(255));
               c = 8'($urandom_range(255));
            end
         endcase
         start_frame(a, f, c);
         push_random($urandom_range(6));
         seal_frame();
         send_frame(-1, 0);
      end else if (roll < 74) begin
         good_frame();
         frame_buf[$urandom_range(frame_buf.size() - 1)] ^= 8'(1 << $urandom_range(7));
         send_frame(-1, 0);
      end else if (roll < 80) begin
         frame_buf.delete();
         push_random($urandom_range(1, 4));
         send_frame(-1, 10);
      end else if (roll < 86) begin
         good_frame();
         send_frame($urandom_range(frame_buf.size() - 1), 0);
      end else if (roll < 88) begin
         overlong_frame();
      end else begin
         frame_buf.delete();
         push_random($urandom_range(1, 12));
         send_frame(-1, 12);
      end
   endtask

   task automatic run_random(input int target);
      while (bytes_sent < target) random_frame();
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // unused upper bits of the narrow registers carry junk
   task automatic set_config(input logic [7:0] a, input logic [6:0] f, input logic [7:0] c,
                             input logic [15:0] dz);
      logic [15:0] junk;
      wait_drained();
      junk = 16'($urandom);
      write_csr(CSR_DEVICE_ADDRESS, {junk[15:8], a});
      write_csr(CSR_FUNCTION_CODE, {junk[8:0], f});
      write_csr(CSR_EXPECTED_BYTE_COUNT, {junk[7:0], c});
      write_csr(CSR_DEAD_ZONE, dz);
      cfg_addr      = a;
      cfg_func      = f;
      cfg_count     = c;
      cfg_dead_zone = dz;
   endtask

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (idle_mode == IDLE_RECEIVER || idle_mode == IDLE_BOTH) begin
            rsp_tready <= ($urandom_range(99) >= 82);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #8_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      req_tuser     = 1'b0;
      rsp_tready    = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_DEVICE_ADDRESS;
      csr_data      = '0;
      idle_mode     = IDLE_NONE;
      hold_request  = 1'b0;
      bytes_sent    = 0;
      cfg_addr      = RST_DEVICE_ADDRESS;
      cfg_func      = RST_FUNCTION_CODE;
      cfg_count     = RST_EXPECTED_BYTE_COUNT;
      cfg_dead_zone = RST_DEAD_ZONE;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames under the reset register values
      start_frame(RST_DEVICE_ADDRESS, {1'b0, RST_FUNCTION_CODE}, RST_EXPECTED_BYTE_COUNT);
      push_value(32'h7FFF_FFFF);
      seal_frame();
      send_frame(-1, 0);
      start_frame(RST_DEVICE_ADDRESS, {1'b1, RST_FUNCTION_CODE}, 8'h02);
      seal_frame();
      send_frame(-1, 0);
      frame_buf.delete();
      frame_buf.push_back(8'hFF);
      send_frame(-1, 0);
      // faulted frame still leaves a negative value behind
      start_frame(RST_DEVICE_ADDRESS, {1'b0, RST_FUNCTION_CODE}, RST_EXPECTED_BYTE_COUNT);
      push_value(32'h8000_0000);
      seal_frame();
      send_frame(1, 0);
      // no value bytes: the crc bytes fill the upper value bytes, the lower two stay held
      start_frame(RST_DEVICE_ADDRESS, {1'b0, RST_FUNCTION_CODE}, RST_EXPECTED_BYTE_COUNT);
      seal_frame();
      send_frame(-1, 0);

      set_config(8'($urandom_range(255)), 7'($urandom_range(127)), 8'd4,
                 16'($urandom_range(500)));
      overlong_frame();
      run_random(150);
      // receiver holds off while minimal replies keep coming
      hold_request = 1'b1;
      repeat (15) begin
         start_frame(cfg_addr, {1'b0, cfg_func}, cfg_count);
         seal_frame();
         send_frame(-1, 0);
      end

      set_config(8'd0, 7'd0, 8'd0, 16'd0);
      idle_mode = IDLE_SENDER;
      run_random(300);

      set_config(8'd255, 7'd127, 8'd255, 16'hFFFF);
      idle_mode = IDLE_RECEIVER;
      run_random(440);

      set_config(8'($urandom_range(255)), 7'($urandom_range(127)), 8'($urandom_range(255)),
                 16'($urandom_range(2000)));
      idle_mode = IDLE_BOTH;
      run_random(560);

      set_config(8'($urandom_range(255)), 7'($urandom_range(127)), 8'($urandom_range(8)),
                 16'($urandom_range(65535)));
      idle_mode = IDLE_NONE;
      run_random(680);

      wait_drained();
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/vchk_pkg.sv
rtl/core/vchk_csr_regs.sv
rtl/core/vchk_frame_track.sv
rtl/core/modbus_reply_voltage_checker_top.sv
tb/modbus_reply_voltage_checker_checker.sv
tb/tb_modbus_reply_voltage_checker_top.sv
